[rtl/core/vwbp_pkg.sv]
// shared types and constants for the variable width bit packer
`default_nettype none

package vwbp_pkg;

    localparam int unsigned BYTE_BITS  = 8;
    localparam int unsigned VALUE_BITS = 32;

    typedef enum logic [1:0] {
        SER_IDLE,
        SER_SHIFT,
        SER_FINISH
    } ser_state_t;

    // serializer to assembler
    typedef struct packed {
        logic bit_valid;
        logic bit_data;
        logic done_valid;
        logic close;
    } bit_link_t;

    // assembler to serializer
    typedef struct packed {
        logic bit_ready;
        logic done_ready;
    } bit_ack_t;

endpackage

`default_nettype wire

[rtl/core/vwbp_serializer.sv]
// holds one input item and sends its value bits msb first, one per cycle unless ack.bit_ready stalls
`default_nettype none

module vwbp_serializer #(
    parameter int unsigned MAX_FIELD_BITS = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               item_valid,
    output logic                                    item_ready,
    input  wire logic                               mode,
    input  wire logic [vwbp_pkg::VALUE_BITS-1:0]    field_value,
    input  wire logic [5:0]                         field_width,
    output vwbp_pkg::bit_link_t                     link,
    input  wire vwbp_pkg::bit_ack_t                 ack
);
    import vwbp_pkg::*;

    localparam int unsigned CW = $clog2(MAX_FIELD_BITS + 1);
    localparam int unsigned IW = (CW > 6) ? CW : 6;

    ser_state_t            state_reg, state_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  close_reg, close_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;

    logic [IW-1:0] width_ext;
    logic [IW-1:0] width_eff;
    logic [IW-1:0] idx_ext;
    logic          cur_bit;

    assign width_ext = IW'(field_width);
    assign width_eff = (width_ext > IW'(MAX_FIELD_BITS)) ? IW'(MAX_FIELD_BITS) : width_ext;
    assign idx_ext   = IW'(cnt_reg - CW'(1));
    assign cur_bit   = (idx_ext < IW'(VALUE_BITS)) ? value_reg[idx_ext[4:0]] : 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SER_IDLE;
            cnt_reg   <= '0;
            close_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            close_reg <= close_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        close_next      = close_reg;
        value_next      = value_reg;
        item_ready      = 1'b0;
        link.bit_valid  = 1'b0;
        link.bit_data   = cur_bit;
        link.done_valid = 1'b0;
        link.close      = close_reg;
        case (state_reg)
            SER_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    value_next = field_value;
                    close_next = mode;
                    cnt_next   = mode ? '0 : CW'(width_eff);
                    if (mode || (width_eff == '0))
                        state_next = SER_FINISH;
                    else
                        state_next = SER_SHIFT;
                end
            end
            SER_SHIFT:
            begin
                link.bit_valid = 1'b1;
                if (ack.bit_ready)
                begin
                    cnt_next = cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1))
                        state_next = SER_FINISH;
                end
            end
            SER_FINISH:
            begin
                link.done_valid = 1'b1;
                if (ack.done_ready)
                    state_next = SER_IDLE;
            end
            default:
            begin
                state_next = SER_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/vwbp_assembler.sv]
// gathers bits into bytes, holds the lazily sent byte and drives the result register
`default_nettype none

module vwbp_assembler (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire vwbp_pkg::bit_link_t link,
    output vwbp_pkg::bit_ack_t       ack,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output logic [7:0]               out_byte,
    output logic                     last_of_run
);
    import vwbp_pkg::*;

    logic [7:0] held_reg, held_next;
    logic [3:0] fill_reg, fill_next;
    logic       pend_valid_reg, pend_valid_next;
    logic [7:0] pend_reg, pend_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_last_reg, out_last_next;

    logic out_free;
    logic full;

    assign out_free     = !out_valid_reg || result_ready;
    assign full         = (fill_reg == 4'(BYTE_BITS));
    assign result_valid = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign last_of_run  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg       <= '0;
            fill_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            held_reg       <= held_next;
            fill_reg       <= fill_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        held_next       = held_reg;
        fill_next       = fill_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !result_ready;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;

        ack.bit_ready  = !(full && pend_valid_reg && !out_free);
        ack.done_ready = link.close ? out_free : (!pend_valid_reg || out_free);

        if (link.bit_valid && ack.bit_ready)
        begin
            if (full)
            begin
                // earlier byte of this item is now known not to be the last
                if (pend_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = pend_reg;
                    out_last_next  = 1'b0;
                end
                pend_valid_next = 1'b1;
                pend_next       = held_reg;
                held_next       = {7'b0, link.bit_data};
                fill_next       = 4'd1;
            end
            else
            begin
                held_next = held_reg | (8'(link.bit_data) << fill_reg[2:0]);
                fill_next = fill_reg + 4'd1;
            end
        end
        else if (link.done_valid && ack.done_ready)
        begin
            if (link.close)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = held_reg;
                out_last_next  = 1'b1;
                held_next      = '0;
                fill_next      = '0;
            end
            else if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_byte_next   = pend_reg;
                out_last_next   = 1'b1;
                pend_valid_next = 1'b0;
            end
        end
    end

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 4'(BYTE_BITS))
        else $error("fill count out of range");

    a_pend_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (fill_reg != 4'd0))
        else $error("pending byte without a following bit");

    a_close_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (link.done_valid && link.close) |-> !pend_valid_reg)
        else $error("close while a byte is pending");

    a_wrap_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (link.bit_valid && ack.bit_ready && full) |=> (fill_reg == 4'd1))
        else $error("fill count did not restart after full byte");

endmodule

`default_nettype wire

[rtl/core/variable_width_bit_packer.sv]
// top level of the lsb first variable width bit packer
// an append item of w bits is loaded, sends its w bits and then finishes; when its finish
//   is taken, any pending byte goes into the result register, marked last of run
// the serializer sends one bit per cycle and takes no new item until the last one has
//   finished; result stalls hold it at a byte boundary or in finish
// reset: rst_n clears the held byte, fill count, pending valid flag and result valid at once
`default_nettype none

module variable_width_bit_packer #(
    parameter int unsigned MAX_FIELD_BITS = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            item_valid,
    output logic                                 item_ready,
    input  wire logic                            mode,
    input  wire logic [vwbp_pkg::VALUE_BITS-1:0] field_value,
    input  wire logic [5:0]                      field_width,
    output logic                                 result_valid,
    input  wire logic                            result_ready,
    output logic [7:0]                           out_byte,
    output logic                                 last_of_run
);
    import vwbp_pkg::*;

    bit_link_t link;
    bit_ack_t  ack;

    vwbp_serializer #(
        .MAX_FIELD_BITS (MAX_FIELD_BITS)
    ) u_serializer (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .mode        (mode),
        .field_value (field_value),
        .field_width (field_width),
        .link        (link),
        .ack         (ack)
    );

    vwbp_assembler u_assembler (
        .clk          (clk),
        .rst_n        (rst_n),
        .link         (link),
        .ack          (ack),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_byte     (out_byte),
        .last_of_run  (last_of_run)
    );

endmodule

`default_nettype wire
